// File: design/scd_pkg.sv
// Shared types and constants for the SUSAN corner detector.
// Used by scd_resp, scd_nms, the top level and the testbench; no dependencies of its own.
package scd_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_DW  = 12;
  localparam int CFG_IW  = 4;
  localparam int ROW_OW  = 11;
  localparam int STR_W   = 5;
  localparam int THR_W   = 8;
  localparam int RAD_W   = 4;
  localparam int OUT_DW  = 32;
  localparam int STR_MAX = 31;

  localparam logic [CFG_IW-1:0] REG_WIDTH  = 4'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 4'd1;
  localparam logic [CFG_IW-1:0] REG_THRESH = 4'd2;
  localparam logic [CFG_IW-1:0] REG_RADIUS = 4'd3;

  typedef enum logic [2:0] {
    TS_IDLE, TS_SETUP, TS_PIX, TS_RESP, TS_NMS, TS_NWAIT, TS_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    SW_IDLE, SW_CTR, SW_WAIT, SW_SWEEP, SW_DRAIN, SW_DONE
  } sweep_state_t;

  // (ring + off) mod rows, with |off| < rows and rows < 128
  function automatic logic [7:0] ring_add(input logic [7:0] ring,
                                          input logic signed [7:0] off,
                                          input logic [7:0] rows);
    logic [8:0] t;
    t = 9'(ring) + 9'(rows) + 9'(off);
    if (t >= 9'({rows, 1'b0})) begin
      t = t - 9'({rows, 1'b0});
    end else if (t >= 9'(rows)) begin
      t = t - 9'(rows);
    end
    return t[7:0];
  endfunction

endpackage

// File: design/scd_resp.sv
// Pixel line store and SUSAN response sweep over the circular mask.
// Depends on scd_pkg.
module scd_resp #(
  parameter int MASK_RADIUS = 3,
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [$clog2(2*MASK_RADIUS+2)-1:0]   wr_ring,
  input  logic [$clog2(MAX_WIDTH)-1:0]         wr_col,
  input  logic [scd_pkg::PIX_W-1:0]            wr_pixel,
  input  logic                                 start,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      pos_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]         pos_col,
  input  logic [$clog2(2*MASK_RADIUS+2)-1:0]   pos_ring,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       img_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      img_h,
  input  logic [scd_pkg::THR_W-1:0]            thresh,
  output logic                                 done,
  output logic [scd_pkg::STR_W-1:0]            resp
);
  import scd_pkg::*;

  function automatic int mask_count(input int r);
    int n;
    n = 0;
    for (int i = -r; i <= r; i++) begin
      for (int j = -r; j <= r; j++) begin
        if (i * i + j * j <= r * r + r) n++;
      end
    end
    return n;
  endfunction

  localparam int ROWS  = 2 * MASK_RADIUS + 2;
  localparam int RGW   = $clog2(ROWS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int OW    = $clog2(MASK_RADIUS + 1) + 1;
  localparam int AW    = RGW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);
  localparam int MPTS  = mask_count(MASK_RADIUS);
  localparam int HALF  = MPTS / 2;
  localparam int SW    = $clog2(MPTS + 1);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;
  logic [AW-1:0]    rd_addr;

  sweep_state_t state_r, state_nxt;
  logic signed [OW-1:0] dy_r, dx_r;
  logic                 pend_r;
  logic [PIX_W-1:0]     ctr_r;
  logic [SW-1:0]        sim_r;

  logic               border, last_pt, in_mask, similar;
  logic [RGW-1:0]     rd_ring;
  logic [CW:0]        col_sum;
  logic [SW:0]        diff;
  logic [PIX_W-1:0]   absd;
  int                 sq;

  localparam logic signed [OW-1:0] RPOS = OW'(MASK_RADIUS);
  localparam logic signed [OW-1:0] RNEG = -RPOS;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_ring, wr_col}] <= wr_pixel;
    end
    rdata_r <= mem[rd_addr];
  end

  assign border = ((HW+1)'(pos_row) < (HW+1)'(MASK_RADIUS)) ||
                  ((HW+1)'(pos_row) + (HW+1)'(MASK_RADIUS) >= (HW+1)'(img_h)) ||
                  ((WW+1)'(pos_col) < (WW+1)'(MASK_RADIUS)) ||
                  ((WW+1)'(pos_col) + (WW+1)'(MASK_RADIUS) >= (WW+1)'(img_w));

  assign last_pt = (dy_r == RPOS) && (dx_r == RPOS);
  assign sq      = int'(dy_r) * int'(dy_r) + int'(dx_r) * int'(dx_r);
  assign in_mask = (sq <= MASK_RADIUS * MASK_RADIUS + MASK_RADIUS);
  assign absd    = (rdata_r > ctr_r) ? rdata_r - ctr_r : ctr_r - rdata_r;
  assign similar = pend_r && (absd < thresh);

  always_comb begin
    if (state_r == SW_SWEEP) begin
      rd_ring = RGW'(ring_add(8'(pos_ring), 8'(dy_r), 8'(ROWS)));
      col_sum = (CW+1)'(pos_col) + (CW+1)'(dx_r);
    end else begin
      rd_ring = pos_ring;
      col_sum = (CW+1)'(pos_col);
    end
    rd_addr = {rd_ring, col_sum[CW-1:0]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SW_IDLE:  if (start) state_nxt = border ? SW_DONE : SW_CTR;
      SW_CTR:   state_nxt = SW_WAIT;
      SW_WAIT:  state_nxt = SW_SWEEP;
      SW_SWEEP: if (last_pt) state_nxt = SW_DRAIN;
      SW_DRAIN: state_nxt = SW_DONE;
      SW_DONE:  state_nxt = SW_IDLE;
      default:  state_nxt = SW_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == SW_DONE);
    diff = (SW+1)'(HALF + 1) - (SW+1)'(sim_r);
    if (border || ((SW+1)'(sim_r) > (SW+1)'(HALF))) begin
      resp = '0;
    end else if (diff > (SW+1)'(STR_MAX)) begin
      resp = STR_W'(STR_MAX);
    end else begin
      resp = STR_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == SW_SWEEP) && in_mask;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      SW_WAIT: begin
        ctr_r <= rdata_r;
        sim_r <= '0;
        dy_r  <= RNEG;
        dx_r  <= RNEG;
      end
      SW_SWEEP: begin
        if (similar) sim_r <= sim_r + SW'(1);
        if (dx_r == RPOS) begin
          dx_r <= RNEG;
          dy_r <= dy_r + OW'(1);
        end else begin
          dx_r <= dx_r + OW'(1);
        end
      end
      SW_DRAIN: begin
        if (similar) sim_r <= sim_r + SW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/scd_nms.sv
// Response line store and non-maximum suppression sweep over the window.
// Depends on scd_pkg.
module scd_nms #(
  parameter int MAX_SUPPRESS_RADIUS = 15,
  parameter int MAX_WIDTH           = 2048,
  parameter int MAX_HEIGHT          = 2048
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         wr_en,
  input  logic [$clog2(2*MAX_SUPPRESS_RADIUS+2)-1:0]   wr_ring,
  input  logic [$clog2(MAX_WIDTH)-1:0]                 wr_col,
  input  logic [scd_pkg::STR_W-1:0]                    wr_resp,
  input  logic                                         start,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]              pos_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]                 pos_col,
  input  logic [$clog2(2*MAX_SUPPRESS_RADIUS+2)-1:0]   pos_ring,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]               img_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]              img_h,
  input  logic [$clog2(MAX_SUPPRESS_RADIUS+1)-1:0]     radius,
  output logic                                         done,
  output logic                                         is_corner,
  output logic [scd_pkg::STR_W-1:0]                    strength
);
  import scd_pkg::*;

  localparam int ROWS  = 2 * MAX_SUPPRESS_RADIUS + 2;
  localparam int RGW   = $clog2(ROWS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NW    = $clog2(MAX_SUPPRESS_RADIUS + 1);
  localparam int OW    = NW + 1;
  localparam int AW    = RGW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  logic [STR_W-1:0] mem [DEPTH];
  logic [STR_W-1:0] rdata_r;
  logic [AW-1:0]    rd_addr;

  sweep_state_t state_r, state_nxt;
  logic signed [OW-1:0] dy_r, dx_r;
  logic                 pend_r, ok_r;
  logic [STR_W-1:0]     s_r;

  logic                 border, last_pt;
  logic signed [OW-1:0] npos, nneg;
  logic [RGW-1:0]       rd_ring;
  logic [CW:0]          col_sum;

  assign npos = signed'({1'b0, radius});
  assign nneg = -npos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_ring, wr_col}] <= wr_resp;
    end
    rdata_r <= mem[rd_addr];
  end

  assign border = ((HW+1)'(pos_row) < (HW+1)'(radius)) ||
                  ((HW+1)'(pos_row) + (HW+1)'(radius) >= (HW+1)'(img_h)) ||
                  ((WW+1)'(pos_col) < (WW+1)'(radius)) ||
                  ((WW+1)'(pos_col) + (WW+1)'(radius) >= (WW+1)'(img_w));

  assign last_pt = (dy_r == npos) && (dx_r == npos);

  always_comb begin
    if (state_r == SW_SWEEP) begin
      rd_ring = RGW'(ring_add(8'(pos_ring), 8'(dy_r), 8'(ROWS)));
      col_sum = (CW+1)'(pos_col) + (CW+1)'(dx_r);
    end else begin
      rd_ring = pos_ring;
      col_sum = (CW+1)'(pos_col);
    end
    rd_addr = {rd_ring, col_sum[CW-1:0]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SW_IDLE:  if (start) state_nxt = SW_CTR;
      SW_CTR:   state_nxt = SW_WAIT;
      SW_WAIT:  state_nxt = (border || rdata_r <= STR_W'(1)) ? SW_DONE : SW_SWEEP;
      SW_SWEEP: if (last_pt) state_nxt = SW_DRAIN;
      SW_DRAIN: state_nxt = SW_DONE;
      SW_DONE:  state_nxt = SW_IDLE;
      default:  state_nxt = SW_IDLE;
    endcase
  end

  always_comb begin
    done      = (state_r == SW_DONE);
    is_corner = ok_r;
    strength  = s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == SW_SWEEP) && !((dy_r == '0) && (dx_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      SW_WAIT: begin
        s_r  <= rdata_r;
        ok_r <= !(border || rdata_r <= STR_W'(1));
        dy_r <= nneg;
        dx_r <= nneg;
      end
      SW_SWEEP: begin
        if (pend_r && rdata_r >= s_r) ok_r <= 1'b0;
        if (dx_r == npos) begin
          dx_r <= nneg;
          dy_r <= dy_r + OW'(1);
        end else begin
          dx_r <= dx_r + OW'(1);
        end
      end
      SW_DRAIN: begin
        if (pend_r && rdata_r >= s_r) ok_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/susan_corner_detector_unit.sv
// Top level of the SUSAN corner detector: stream ports, frame counters, sequencer.
// Depends on scd_pkg, scd_resp and scd_nms.
//
// Pixels enter in raster order; each beat yields one result beat. Per pixel the
// block stores the pixel, sweeps the (2R+1)^2 square around the response position
// through the pixel line store (one read per cycle), then sweeps the (2n+1)^2
// suppression window through the response line store. A sweep is skipped where
// its window crosses the image border, and the result may wait on out_tready.
// Each line store has a single read port. Size, threshold and radius are taken
// at the first beat of a frame; decision k appears on beat k + (n+R)*W + n + R,
// earlier beats carry tuser low. The stores need no clearing after reset.
module susan_corner_detector_unit #(
  parameter int MASK_RADIUS         = 3,
  parameter int MAX_SUPPRESS_RADIUS = 15,
  parameter int MAX_WIDTH           = 2048,
  parameter int MAX_HEIGHT          = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [scd_pkg::PIX_W-1:0]    in_tdata,   // [7:0] pixel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [scd_pkg::OUT_DW-1:0]   out_tdata,  // [0] is_corner, [11:1] corner_row,
                                                   // [22:12] corner_col, [27:23] strength
  output logic                         out_tuser,  // [0] decided
  output logic                         out_tlast,  // frame_done
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [scd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [scd_pkg::CFG_DW-1:0]   cfg_data
);
  import scd_pkg::*;

  localparam int PROWS = 2 * MASK_RADIUS + 2;
  localparam int RROWS = 2 * MAX_SUPPRESS_RADIUS + 2;
  localparam int PRW   = $clog2(PROWS);
  localparam int RRW   = $clog2(RROWS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NW    = $clog2(MAX_SUPPRESS_RADIUS + 1);
  localparam int KW    = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2;

  logic [CFG_DW-1:0] cfg_w_r, cfg_h_r;
  logic [THR_W-1:0]  cfg_thr_r;
  logic [RAD_W-1:0]  cfg_n_r;

  logic [WW-1:0]    cur_w_r;
  logic [HW-1:0]    cur_h_r;
  logic [THR_W-1:0] cur_thr_r;
  logic [NW-1:0]    cur_n_r;
  logic [KW-1:0]    total_r, lagr_r, lag_r, k_r;

  logic [CW-1:0]  in_c_r, p_c_r, q_c_r;
  logic [HW-1:0]  p_r_r, q_r_r;
  logic [PRW-1:0] in_ring_r, p_ring_r;
  logic [RRW-1:0] p_rring_r, q_rring_r;
  logic [PIX_W-1:0] pix_r;

  top_state_t state_r, state_nxt;

  logic out_tvalid_r, out_tuser_r, out_tlast_r;
  logic [OUT_DW-1:0] out_tdata_r;

  logic [15:0]  w_in, h_in;
  logic [7:0]   n_in;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic [NW-1:0] n_clamp;

  logic pix_we, p_act, decided, frame_done, out_free, out_load;
  logic in_wrap, p_wrap, q_wrap;
  logic resp_start, resp_done, nms_start, nms_done, nms_corner;
  logic [STR_W-1:0] resp_val, nms_str;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= CFG_DW'(640);
      cfg_h_r   <= CFG_DW'(480);
      cfg_thr_r <= THR_W'(20);
      cfg_n_r   <= RAD_W'(5);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  cfg_w_r   <= cfg_data;
        REG_HEIGHT: cfg_h_r   <= cfg_data;
        REG_THRESH: cfg_thr_r <= cfg_data[THR_W-1:0];
        REG_RADIUS: cfg_n_r   <= cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w_in = 16'(cfg_w_r);
    h_in = 16'(cfg_h_r);
    n_in = 8'(cfg_n_r);
    if (w_in < 16'd16)                 w_clamp = WW'(16);
    else if (w_in > 16'(MAX_WIDTH))    w_clamp = WW'(MAX_WIDTH);
    else                               w_clamp = WW'(w_in);
    if (h_in < 16'd16)                 h_clamp = HW'(16);
    else if (h_in > 16'(MAX_HEIGHT))   h_clamp = HW'(MAX_HEIGHT);
    else                               h_clamp = HW'(h_in);
    if (n_in == 8'd0)                            n_clamp = NW'(1);
    else if (n_in > 8'(MAX_SUPPRESS_RADIUS))     n_clamp = NW'(MAX_SUPPRESS_RADIUS);
    else                                         n_clamp = NW'(n_in);
  end

  assign pix_we     = (state_r == TS_PIX) && (k_r < total_r);
  assign p_act      = (k_r >= lagr_r) && (p_r_r < cur_h_r);
  assign decided    = (k_r >= lag_r);
  assign frame_done = decided && (q_r_r == cur_h_r - HW'(1)) &&
                      (WW'(q_c_r) == cur_w_r - WW'(1));
  assign out_free   = !out_tvalid_r || out_tready;
  assign in_wrap    = (WW'(in_c_r) + WW'(1) == cur_w_r);
  assign p_wrap     = (WW'(p_c_r) + WW'(1) == cur_w_r);
  assign q_wrap     = (WW'(q_c_r) + WW'(1) == cur_w_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TS_IDLE:  if (in_tvalid) state_nxt = (k_r == '0) ? TS_SETUP : TS_PIX;
      TS_SETUP: state_nxt = TS_PIX;
      TS_PIX:   state_nxt = p_act ? TS_RESP : TS_NMS;
      TS_RESP:  if (resp_done) state_nxt = TS_NMS;
      TS_NMS:   state_nxt = decided ? TS_NWAIT : TS_OUT;
      TS_NWAIT: if (nms_done) state_nxt = TS_OUT;
      TS_OUT:   if (out_free) state_nxt = TS_IDLE;
      default:  state_nxt = TS_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == TS_IDLE);
    resp_start = (state_r == TS_PIX) && p_act;
    nms_start  = (state_r == TS_NMS) && decided;
    out_load   = (state_r == TS_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= TS_IDLE;
      out_tvalid_r <= 1'b0;
      k_r          <= '0;
      in_c_r       <= '0;
      in_ring_r    <= '0;
      p_c_r        <= '0;
      p_r_r        <= '0;
      p_ring_r     <= '0;
      p_rring_r    <= '0;
      q_c_r        <= '0;
      q_r_r        <= '0;
      q_rring_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (out_load) begin
        if (frame_done) begin
          k_r       <= '0;
          in_c_r    <= '0;
          in_ring_r <= '0;
          p_c_r     <= '0;
          p_r_r     <= '0;
          p_ring_r  <= '0;
          p_rring_r <= '0;
          q_c_r     <= '0;
          q_r_r     <= '0;
          q_rring_r <= '0;
        end else begin
          k_r <= k_r + KW'(1);
          if (k_r < total_r) begin
            in_c_r <= in_wrap ? '0 : in_c_r + CW'(1);
            if (in_wrap) in_ring_r <= (in_ring_r == PRW'(PROWS - 1)) ? '0 : in_ring_r + PRW'(1);
          end
          if (p_act) begin
            p_c_r <= p_wrap ? '0 : p_c_r + CW'(1);
            if (p_wrap) begin
              p_r_r     <= p_r_r + HW'(1);
              p_ring_r  <= (p_ring_r == PRW'(PROWS - 1)) ? '0 : p_ring_r + PRW'(1);
              p_rring_r <= (p_rring_r == RRW'(RROWS - 1)) ? '0 : p_rring_r + RRW'(1);
            end
          end
          if (decided) begin
            q_c_r <= q_wrap ? '0 : q_c_r + CW'(1);
            if (q_wrap) begin
              q_r_r     <= q_r_r + HW'(1);
              q_rring_r <= (q_rring_r == RRW'(RROWS - 1)) ? '0 : q_rring_r + RRW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r <= in_tdata;
      if (k_r == '0) begin
        cur_w_r   <= w_clamp;
        cur_h_r   <= h_clamp;
        cur_thr_r <= cfg_thr_r;
        cur_n_r   <= n_clamp;
      end
    end
    if (state_r == TS_SETUP) begin
      total_r <= KW'(cur_w_r) * KW'(cur_h_r);
      lagr_r  <= KW'(MASK_RADIUS) * KW'(cur_w_r) + KW'(MASK_RADIUS);
      lag_r   <= (KW'(cur_n_r) + KW'(MASK_RADIUS)) * KW'(cur_w_r) +
                 KW'(cur_n_r) + KW'(MASK_RADIUS);
    end
    if (out_load) begin
      out_tuser_r <= decided;
      out_tlast_r <= frame_done;
      if (decided) begin
        out_tdata_r <= {4'b0, nms_str, ROW_OW'(q_c_r), ROW_OW'(q_r_r), nms_corner};
      end else begin
        out_tdata_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  scd_resp #(
    .MASK_RADIUS (MASK_RADIUS),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_resp (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (pix_we),
    .wr_ring  (in_ring_r),
    .wr_col   (in_c_r),
    .wr_pixel (pix_r),
    .start    (resp_start),
    .pos_row  (p_r_r),
    .pos_col  (p_c_r),
    .pos_ring (p_ring_r),
    .img_w    (cur_w_r),
    .img_h    (cur_h_r),
    .thresh   (cur_thr_r),
    .done     (resp_done),
    .resp     (resp_val)
  );

  scd_nms #(
    .MAX_SUPPRESS_RADIUS (MAX_SUPPRESS_RADIUS),
    .MAX_WIDTH           (MAX_WIDTH),
    .MAX_HEIGHT          (MAX_HEIGHT)
  ) u_nms (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     ((state_r == TS_RESP) && resp_done),
    .wr_ring   (p_rring_r),
    .wr_col    (p_c_r),
    .wr_resp   (resp_val),
    .start     (nms_start),
    .pos_row   (q_r_r),
    .pos_col   (q_c_r),
    .pos_ring  (q_rring_r),
    .img_w     (cur_w_r),
    .img_h     (cur_h_r),
    .radius    (cur_n_r),
    .done      (nms_done),
    .is_corner (nms_corner),
    .strength  (nms_str)
  );

endmodule

// File: design/scd_checker.sv
// Port-level checks on the result stream of the corner detector.
// Depends on susan_corner_detector_unit; attached by bind.
module scd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_undecided_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0 && !out_tlast)
    else $error("undecided beat carries data");

  a_corner_strength: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[27:23] > 5'd1)
    else $error("corner with response not above one");

  a_last_decided: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end on undecided beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind susan_corner_detector_unit scd_checker u_scd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/susan_corner_detector_unit_tb.sv
// Self-checking testbench for susan_corner_detector_unit: streams random and
// patterned frames through the block and predicts every result beat.
// Depends on scd_pkg and the design sources.
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] data;
  logic        user;
  logic        last;
} corner_beat_t;

class corner_scoreboard;
  byte unsigned pix_rows[8][2048];
  bit [4:0]     resp_rows[32][2048];
  int           reg_w, reg_h, reg_thr, reg_n;
  int           cur_w, cur_h, cur_thr, cur_n;
  int           item_cnt, in_row, in_col;
  int           mask_dy[37], mask_dx[37], mask_pts;
  corner_beat_t pending[$];
  int           errors;

  function new();
    mask_pts = 0;
    for (int i = -3; i <= 3; i++)
      for (int j = -3; j <= 3; j++)
        if (i * i + j * j <= 12) begin
          mask_dy[mask_pts] = i;
          mask_dx[mask_pts] = j;
          mask_pts++;
        end
    reg_w = 640; reg_h = 480; reg_thr = 20; reg_n = 5;
    item_cnt = 0; in_row = 0; in_col = 0; errors = 0;
  endfunction

  function int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function void write_reg(logic [3:0] idx, logic [11:0] val);
    case (idx)
      scd_pkg::REG_WIDTH:  reg_w = int'(val);
      scd_pkg::REG_HEIGHT: reg_h = int'(val);
      scd_pkg::REG_THRESH: reg_thr = int'(val[7:0]);
      scd_pkg::REG_RADIUS: reg_n = int'(val[3:0]);
      default: ;
    endcase
  endfunction

  function bit [4:0] mask_response(int r, int c);
    int sim, cnt, d;
    int ctr, v;
    if (r < 3 || r + 3 >= cur_h || c < 3 || c + 3 >= cur_w) return 5'd0;
    sim = 0;
    ctr = int'(pix_rows[r % 8][c]);
    for (int k = 0; k < mask_pts; k++) begin
      v = int'(pix_rows[(r + mask_dy[k]) % 8][c + mask_dx[k]]);
      d = (v > ctr) ? v - ctr : ctr - v;
      if (d < cur_thr) sim++;
    end
    cnt = sim - 1;
    if (cnt < mask_pts / 2) return ((mask_pts / 2 - cnt) > 31) ? 5'd31 : 5'(mask_pts / 2 - cnt);
    return 5'd0;
  endfunction

  function bit local_max(int r, int c, bit [4:0] s);
    if (r < cur_n || r + cur_n >= cur_h || c < cur_n || c + cur_n >= cur_w) return 0;
    if (s <= 1) return 0;
    for (int y = r - cur_n; y <= r + cur_n; y++)
      for (int x = c - cur_n; x <= c + cur_n; x++) begin
        if (y == r && x == c) continue;
        if (resp_rows[y % 32][x] >= s) return 0;
      end
    return 1;
  endfunction

  // returns 1 when this beat carries the last decision of the frame
  function bit note_pixel(logic [7:0] p);
    int total, lag_r, lag, pos, r, c;
    bit [4:0] s;
    corner_beat_t b;
    if (item_cnt == 0) begin
      cur_w = clamp(reg_w, 16, 2048);
      cur_h = clamp(reg_h, 16, 2048);
      cur_thr = reg_thr;
      cur_n = clamp(reg_n, 1, 15);
      in_row = 0; in_col = 0;
    end
    total = cur_w * cur_h;
    lag_r = 3 * cur_w + 3;
    lag = (cur_n + 3) * cur_w + cur_n + 3;
    if (item_cnt < total) begin
      pix_rows[in_row % 8][in_col] = p;
      in_col++;
      if (in_col >= cur_w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (item_cnt >= lag_r && item_cnt - lag_r < total) begin
      pos = item_cnt - lag_r;
      resp_rows[(pos / cur_w) % 32][pos % cur_w] = mask_response(pos / cur_w, pos % cur_w);
    end
    b.data = '0; b.user = 0; b.last = 0;
    if (item_cnt >= lag) begin
      pos = item_cnt - lag;
      r = pos / cur_w;
      c = pos % cur_w;
      s = resp_rows[r % 32][c];
      b.user = 1;
      b.data = {4'b0, s, 11'(c), 11'(r), local_max(r, c, s)};
      if (pos + 1 >= total) begin
        b.last = 1;
        pending.push_back(b);
        item_cnt = 0;
        return 1;
      end
    end
    pending.push_back(b);
    item_cnt++;
    return 0;
  endfunction

  function void check_beat(logic [31:0] data, logic user, logic last);
    corner_beat_t b;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat data=%h user=%b last=%b", $time, data, user, last);
      errors++;
      return;
    end
    b = pending.pop_front();
    if (data !== b.data || user !== b.user || last !== b.last) begin
      $display("%0t: mismatch expected data=%h user=%b last=%b actual data=%h user=%b last=%b",
               $time, b.data, b.user, b.last, data, user, last);
      errors++;
    end
  endfunction
endclass

module susan_corner_detector_unit_tb;
  import scd_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  corner_scoreboard sb = new();
  int               idle_pct;
  int               stall_pct;
  int               hold_cycles;

  susan_corner_detector_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: check each accepted beat, then pick tready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_cfg(logic [3:0] idx, logic [11:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_frame(bit directed, int hold_at, int pause_at);
    int w, k, r0, c0, gap;
    logic [7:0] lo, hi, p;
    bit done;
    w = sb.clamp(sb.reg_w, 16, 2048);
    r0 = $urandom_range(2, 12);
    c0 = $urandom_range(2, 12);
    lo = 8'($urandom);
    hi = 8'($urandom);
    k = 0;
    done = 0;
    while (!done) begin
      case ((k / 80) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      if (directed && k < 24) begin
        case (k % 6)
          0: p = 8'h00;
          1: p = 8'hFF;
          2: p = 8'h55;
          3: p = 8'hAA;
          4: p = 8'h01;
          default: p = 8'h80;
        endcase
      end else if ($urandom_range(7) == 0) begin
        p = 8'($urandom);
      end else begin
        p = ((k / w) % 16 >= r0 && (k % w) >= c0) ? hi : lo;
      end
      if (k == hold_at) hold_cycles = 3000;
      in_tvalid <= 1;
      in_tdata  <= p;
      do @(posedge clk); while (!in_tready);
      done = sb.note_pixel(p);
      if (k == pause_at) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end else if (!done && $urandom_range(99) < idle_pct) begin
        gap = $urandom_range(1, 4);
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      k++;
    end
    in_tvalid <= 0;
    wait_drained();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // ignored indexes, all data bits
    write_cfg(4'hF, 12'hFFF);
    write_cfg(4'h4, 12'h000);
    write_cfg(4'h8, 12'h5A5);
    write_cfg(REG_WIDTH, 12'd16);
    write_cfg(REG_HEIGHT, 12'd16);
    write_cfg(REG_THRESH, 12'd20);
    write_cfg(REG_RADIUS, 12'd1);
    run_frame(1, 100, -1);

    // below-range sizes and radius saturate, zero threshold
    write_cfg(REG_WIDTH, 12'd0);
    write_cfg(REG_HEIGHT, 12'd3);
    write_cfg(REG_THRESH, 12'd0);
    write_cfg(REG_RADIUS, 12'd0);
    run_frame(0, -1, 150);

    write_cfg(REG_THRESH, 12'($urandom_range(1, 60)));
    write_cfg(REG_RADIUS, 12'd15);
    run_frame(0, 200, -1);

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
